// ===== hdl/ntwa_pkg.sv =====
`default_nettype none

package ntwa_pkg;

   localparam int DEF_ENTRIES = 16;

   // request kinds
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EXISTS = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;

   // register indexes
   localparam logic CSR_INVALIDATE = 1'b0;
   localparam logic CSR_REMOVE     = 1'b1;

   localparam logic [15:0] INVALIDATE_RESET = 16'd30;
   localparam logic [15:0] REMOVE_RESET     = 16'd30;
   localparam logic [15:0] AGE_MAX          = 16'hFFFF;

   // one table row as held in the memory
   typedef struct packed {
      logic        used;
      logic        valid;
      logic [15:0] age;
      logic [15:0] key;
      logic [31:0] in_addr;
      logic [31:0] outside;
   } row_type;

   // verdict of the shared compare unit on one row
   typedef struct packed {
      logic match;
      logic free;
      logic wr_back;
   } unit_res_type;

endpackage

`default_nettype wire

// ===== hdl/nat_table_with_aging.sv =====
`default_nettype none

// channel | direction | handshake             | payload
// req     | in        | req_tvalid/req_tready | tuser: req_type; tdata: key, addresses
// rsp     | out       | rsp_tvalid/rsp_tready | tdata: hit, hit_valid, addresses, status
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata (always ready)
//
// every request walks all ENTRIES rows through the single table read port and
// the shared compare unit, one row per cycle; a new request is accepted only
// once the scan and the finish step of the last one are done
// after reset a clearing pass over all rows runs before req_tready rises
// a finished response sits in the output register; the next request is taken
// meanwhile and only waits at its end if the previous response is still held

module nat_table_with_aging
   import ntwa_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request transaction
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type
   input  wire logic [79:0] req_tdata,   // [15:0] key_id, [47:16] inside_addr,
                                         // [79:48] outside_addr
   // response transaction
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [0] hit, [1] hit_valid,
                                         // [33:2] inside_addr_out,
                                         // [65:34] outside_addr_out,
                                         // [67:66] status, rest zero
   // register write transaction
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // one-hot sequencer
   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic        rd_pend_ff, rd_pend_in;        // a row read is in flight
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;     // row whose data arrives now

   // the request being worked on
   logic [1:0]  cur_type_ff, cur_type_in;
   logic [15:0] cur_key_ff, cur_key_in;
   logic [31:0] cur_in_ff, cur_in_in;
   logic [31:0] cur_out_ff, cur_out_in;

   // scan findings
   logic        found_ff, found_in;
   logic        free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic        hit_valid_ff, hit_valid_in;
   logic [31:0] hit_in_ff, hit_in_in;
   logic [31:0] hit_out_ff, hit_out_in;

   // timeout registers
   logic [15:0] inv_ff, inv_in;
   logic [15:0] rem_ff, rem_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;

   // table port
   logic        mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   row_type     mem_wr_data;
   logic        mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   row_type     mem_rd_data;

   unit_res_type unit_res;
   row_type     aged_row;

   logic        issue;
   logic        rsp_free;
   logic        rsp_hit;
   logic        rsp_hit_valid;
   logic [31:0] rsp_in_addr;
   logic [31:0] rsp_out_addr;
   logic [1:0]  rsp_status;

   ntwa_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // shared compare / aging unit, fed one row per cycle
   ntwa_unit u_unit (
      .row_i    (mem_rd_data),
      .key_i    (cur_key_ff),
      .inv_to   (inv_ff),
      .rem_to   (rem_ff),
      .res      (unit_res),
      .aged_row (aged_row)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign issue    = (scan_cnt_ff < CNT_W'(ENTRIES));
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // response fields from the scan findings
   always_comb begin
      rsp_hit       = 1'b0;
      rsp_hit_valid = 1'b0;
      rsp_in_addr   = 32'd0;
      rsp_out_addr  = 32'd0;
      rsp_status    = STAT_OK;
      case (cur_type_ff)
         REQ_INSERT: begin
            if (found_ff) begin
               rsp_status = STAT_EXISTS;
            end else if (!free_found_ff) begin
               rsp_status = STAT_FULL;
            end
         end
         REQ_LOOKUP: begin
            if (found_ff) begin
               rsp_hit       = 1'b1;
               rsp_hit_valid = hit_valid_ff;
               rsp_in_addr   = hit_in_ff;
               rsp_out_addr  = hit_out_ff;
            end
         end
         default: begin
            // tick and unused kind answer all zero
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      cur_type_in   = cur_type_ff;
      cur_key_in    = cur_key_ff;
      cur_in_in     = cur_in_ff;
      cur_out_in    = cur_out_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_valid_in  = hit_valid_ff;
      hit_in_in     = hit_in_ff;
      hit_out_in    = hit_out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = rd_idx_ff;
      mem_wr_data   = aged_row;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = scan_cnt_ff[IDX_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            // zero one row per cycle: used, valid and age cleared
            mem_wr_en   = 1'b1;
            mem_wr_addr = scan_cnt_ff[IDX_W-1:0];
            mem_wr_data = '0;
            scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            if (scan_cnt_ff == CNT_W'(ENTRIES - 1)) begin
               scan_cnt_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cur_type_in   = req_tuser;
               cur_key_in    = req_tdata[15:0];
               cur_in_in     = req_tdata[47:16];
               cur_out_in    = req_tdata[79:48];
               found_in      = 1'b0;
               free_found_in = 1'b0;
               scan_cnt_in   = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read row n while the unit judges row n-1
            if (issue) begin
               mem_rd_en   = 1'b1;
               rd_pend_in  = 1'b1;
               rd_idx_in   = scan_cnt_ff[IDX_W-1:0];
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_FINISH;
            end
            if (rd_pend_ff) begin
               if (unit_res.match && !found_ff) begin
                  found_in     = 1'b1;
                  hit_valid_in = mem_rd_data.valid;
                  hit_in_in    = mem_rd_data.in_addr;
                  hit_out_in   = mem_rd_data.outside;
               end
               if (unit_res.free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if ((cur_type_ff == REQ_TICK) && unit_res.wr_back) begin
                  mem_wr_en = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               if ((cur_type_ff == REQ_INSERT) && !found_ff && free_found_ff) begin
                  mem_wr_en           = 1'b1;
                  mem_wr_addr         = free_idx_ff;
                  mem_wr_data.used    = 1'b1;
                  mem_wr_data.valid   = 1'b1;
                  mem_wr_data.age     = 16'd0;
                  mem_wr_data.key     = cur_key_ff;
                  mem_wr_data.in_addr = cur_in_ff;
                  mem_wr_data.outside = cur_out_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, rsp_status, rsp_out_addr, rsp_in_addr,
                               rsp_hit_valid, rsp_hit};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in    = ST_CLEAR;
            scan_cnt_in = '0;
         end
      endcase
   end

   // timeout registers, written at any time the port sees a transaction
   always_comb begin
      inv_in = inv_ff;
      rem_in = rem_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_INVALIDATE: inv_in = csr_wdata;
            CSR_REMOVE:     rem_in = csr_wdata;
            default: begin
               inv_in = inv_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_cnt_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         inv_ff       <= INVALIDATE_RESET;
         rem_ff       <= REMOVE_RESET;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         inv_ff       <= inv_in;
         rem_ff       <= rem_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      cur_type_ff   <= cur_type_in;
      cur_key_ff    <= cur_key_in;
      cur_in_ff     <= cur_in_in;
      cur_out_ff    <= cur_out_in;
      found_ff      <= found_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_valid_ff  <= hit_valid_in;
      hit_in_ff     <= hit_in_in;
      hit_out_ff    <= hit_out_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // a response only appears out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   // a row read in flight belongs to a scan
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_SCAN))
      else $error("row data pending outside scan");

   // the scan counter never goes past ENTRIES
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= CNT_W'(ENTRIES))
      else $error("scan counter out of range");

   // no table write while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr_en)
      else $error("table written while idle");

endmodule

`default_nettype wire

// ===== hdl/ntwa_store.sv =====
`default_nettype none

module ntwa_store
   import ntwa_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   localparam int IDX_W = $clog2(ENTRIES)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire row_type          wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output row_type               rd_data
);

   row_type row_mem_ff [ENTRIES];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/ntwa_unit.sv =====
`default_nettype none

module ntwa_unit
   import ntwa_pkg::*;
(
   input  wire row_type       row_i,
   input  wire logic [15:0]   key_i,
   input  wire logic [15:0]   inv_to,
   input  wire logic [15:0]   rem_to,
   output unit_res_type       res,
   output row_type            aged_row
);

   logic [15:0] age_next;
   logic        valid_next;

   always_comb begin
      res.match   = row_i.used && (row_i.key == key_i);
      res.free    = !row_i.used;
      res.wr_back = row_i.used;

      // saturating age step, then the two timeout checks
      age_next   = (row_i.age == AGE_MAX) ? row_i.age : row_i.age + 16'd1;
      valid_next = row_i.valid && !(age_next > inv_to);

      aged_row       = row_i;
      aged_row.age   = age_next;
      aged_row.valid = valid_next;
      if (age_next >= rem_to) begin
         aged_row.used  = 1'b0;
         aged_row.valid = 1'b0;
         aged_row.age   = 16'd0;
      end
   end

endmodule

`default_nettype wire

// ===== dv/nat_table_with_aging_tb.sv =====
`default_nettype none

module nat_table_with_aging_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ntwa_pkg::*;

   localparam int ENTRIES = DEF_ENTRIES;
   // request kind that the block leaves alone, answered with an all-zero response
   localparam logic [1:0] REQ_RSVD = 2'd3;
   // one table scan per request plus a little margin
   localparam int LATENCY = ENTRIES + 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int KEY_POOL = 20;

   // one request as it travels on the req channel
   typedef struct {
      logic [1:0]  kind;
      logic [15:0] key;
      logic [31:0] ia;
      logic [31:0] oa;
   } xlate_req_type;

   // one response, field by field
   typedef struct packed {
      logic        hit;
      logic        hit_valid;
      logic [31:0] ia;
      logic [31:0] oa;
      logic [1:0]  status;
   } xlate_rsp_type;

   // directed row: count > 1 repeats the request with the key stepped up
   typedef struct {
      xlate_req_type req;
      int            count;
      bit            typed;
      xlate_rsp_type rsp;
   } dir_row_type;

   localparam xlate_rsp_type RSP_NONE = '0;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   // shadow copy of the translation table and its timeouts
   logic [15:0] tbl_key   [ENTRIES] = '{default: '0};
   logic [31:0] tbl_ia    [ENTRIES] = '{default: '0};
   logic [31:0] tbl_oa    [ENTRIES] = '{default: '0};
   logic [15:0] tbl_age   [ENTRIES] = '{default: '0};
   logic        tbl_used  [ENTRIES] = '{default: 1'b0};
   logic        tbl_valid [ENTRIES] = '{default: 1'b0};
   logic [15:0] cfg_inval  = INVALIDATE_RESET;
   logic [15:0] cfg_remove = REMOVE_RESET;

   xlate_rsp_type xlate_expected[$];
   int          mismatch_count = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;      // no idling on either side
   int          stall_left = 0;

   nat_table_with_aging dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // slot holding the key, -1 when absent; only used slots are looked at
   function automatic int find_key(logic [15:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_used[i] && tbl_key[i] == key) return i;
      return -1;
   endfunction

   // applies one request to the shadow table and returns its response
   function automatic xlate_rsp_type nat_predict(xlate_req_type r);
      xlate_rsp_type o;
      int            slot;
      o = '0;
      slot = -1;
      case (r.kind)
         REQ_INSERT: begin
            if (find_key(r.key) >= 0) begin
               o.status = STAT_EXISTS;
            end else begin
               // lowest-numbered free slot wins
               for (int i = 0; i < ENTRIES; i++)
                  if (!tbl_used[i] && slot < 0) slot = i;
               if (slot < 0) begin
                  o.status = STAT_FULL;
               end else begin
                  tbl_key[slot]   = r.key;
                  tbl_ia[slot]    = r.ia;
                  tbl_oa[slot]    = r.oa;
                  tbl_age[slot]   = '0;
                  tbl_used[slot]  = 1'b1;
                  tbl_valid[slot] = 1'b1;
               end
            end
         end
         REQ_LOOKUP: begin
            // a lookup never refreshes the age
            slot = find_key(r.key);
            if (slot >= 0) begin
               o.hit       = 1'b1;
               o.hit_valid = tbl_valid[slot];
               o.ia        = tbl_ia[slot];
               o.oa        = tbl_oa[slot];
            end
         end
         REQ_TICK: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_used[i]) begin
                  if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 16'd1;
                  if (tbl_valid[i] && tbl_age[i] > cfg_inval) tbl_valid[i] = 1'b0;
                  if (tbl_age[i] >= cfg_remove) begin
                     tbl_used[i]  = 1'b0;
                     tbl_valid[i] = 1'b0;
                     tbl_age[i]   = '0;
                  end
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic dir_row_type mk_row(logic [1:0] kind, logic [15:0] key,
                                          logic [31:0] ia, logic [31:0] oa,
                                          int count, bit typed,
                                          xlate_rsp_type rsp);
      dir_row_type d;
      d.req.kind = kind;
      d.req.key  = key;
      d.req.ia   = ia;
      d.req.oa   = oa;
      d.count    = count;
      d.typed    = typed;
      d.rsp      = rsp;
      return d;
   endfunction

   function automatic void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $error("%s: expected %0h, got %0h", name, e, a);
         mismatch_count++;
      end
   endfunction

   // drives one request transaction; valid stays high afterwards so that
   // back-to-back requests need no drop in between
   task automatic send_req(xlate_req_type r, bit typed, xlate_rsp_type typed_rsp);
      xlate_rsp_type pred;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = r.kind;
      req_tdata  = {r.oa, r.ia, r.key};
      do @(posedge clock); while (!req_tready);
      // the shadow table moves with every accepted transaction
      pred = nat_predict(r);
      xlate_expected.push_back(typed ? typed_rsp : pred);
   endtask

   // stops requests and waits for every outstanding response
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (xlate_expected.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_INVALIDATE) cfg_inval = val;
      else cfg_remove = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // response side backpressure: random stall bursts unless quiet
   always @(negedge clock) begin
      if (stall_left > 0 && !quiet) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
      end
   end

   // response checker, oldest expectation first
   always @(posedge clock) begin
      xlate_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (xlate_expected.size() == 0) begin
            $error("response transaction with no request outstanding: %0h", rsp_tdata);
            mismatch_count++;
         end else begin
            e = xlate_expected.pop_front();
            cmp_field("hit", e.hit, rsp_tdata[0]);
            cmp_field("hit_valid", e.hit_valid, rsp_tdata[1]);
            cmp_field("inside_addr_out", e.ia, rsp_tdata[33:2]);
            cmp_field("outside_addr_out", e.oa, rsp_tdata[65:34]);
            cmp_field("status", e.status, rsp_tdata[67:66]);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** nat_table_with_aging: FAILED **");
         $finish;
      end
   end

   initial begin
      dir_row_type   dir_rows[$];
      xlate_req_type r;
      logic [15:0] key_pool[KEY_POOL];
      logic [15:0] last_key;
      int unsigned inval_set[NUM_PHASES];
      int unsigned remove_set[NUM_PHASES];
      int          roll;
      int          pick;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, run with the reset timeouts
      // misses and the ignored request kind come back all zero
      dir_rows.push_back(mk_row(REQ_LOOKUP, 16'h0000, '0, '0, 1, 1'b1, RSP_NONE));
      dir_rows.push_back(mk_row(REQ_RSVD, 16'hFFFF, '1, '1, 1, 1'b1, RSP_NONE));
      // extremes of key and addresses
      dir_rows.push_back(mk_row(REQ_INSERT, 16'h0000, '0, '0, 1, 1'b1, RSP_NONE));
      dir_rows.push_back(mk_row(REQ_INSERT, 16'hFFFF, '1, '1, 1, 1'b1, RSP_NONE));
      dir_rows.push_back(mk_row(REQ_LOOKUP, 16'hFFFF, '0, '0, 1, 1'b1,
                                xlate_rsp_type'{1'b1, 1'b1, '1, '1, STAT_OK}));
      dir_rows.push_back(mk_row(REQ_LOOKUP, 16'h0000, '1, '1, 1, 1'b1,
                                xlate_rsp_type'{1'b1, 1'b1, '0, '0, STAT_OK}));
      // duplicate key leaves the entry alone
      dir_rows.push_back(mk_row(REQ_INSERT, 16'hFFFF, 32'h12345678, 32'h9ABCDEF0, 1, 1'b1,
                                xlate_rsp_type'{1'b0, 1'b0, '0, '0, STAT_EXISTS}));
      dir_rows.push_back(mk_row(REQ_TICK, 16'h5A5A, '0, '0, 1, 1'b1, RSP_NONE));
      // fill the remaining fourteen slots
      dir_rows.push_back(mk_row(REQ_INSERT, 16'h0001, 32'h0A000001, 32'hC0A80001,
                                ENTRIES - 2, 1'b0, RSP_NONE));
      // table full, and the refused key stays absent
      dir_rows.push_back(mk_row(REQ_INSERT, 16'h1234, 32'h01020304, 32'h05060708, 1, 1'b1,
                                xlate_rsp_type'{1'b0, 1'b0, '0, '0, STAT_FULL}));
      dir_rows.push_back(mk_row(REQ_LOOKUP, 16'h1234, '0, '0, 1, 1'b1, RSP_NONE));

      foreach (dir_rows[i]) begin
         for (int k = 0; k < dir_rows[i].count; k++) begin
            r     = dir_rows[i].req;
            r.key = r.key + 16'(k);
            r.ia  = r.ia + 32'(k);
            r.oa  = r.oa ^ 32'(k);
            send_req(r, dir_rows[i].typed, dir_rows[i].rsp);
         end
      end

      // timeout settings per phase: reset values, invalidate before remove,
      // zero (everything freed each tick), entries that never leave,
      // both at the top, remove before invalidate, then random ones
      inval_set  = '{30, 3, 0, 1, 65535, 8, 0, 0};
      remove_set = '{30, 8, 0, 65535, 65535, 4, 0, 0};
      last_key = '0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p >= NUM_PHASES - 2) begin
            inval_set[p]  = $urandom_range(1, 40);
            remove_set[p] = $urandom_range(1, 40);
         end
         // registers change only with nothing in flight
         settle();
         csr_write(CSR_INVALIDATE, 16'(inval_set[p]));
         csr_write(CSR_REMOVE, 16'(remove_set[p]));
         quiet = (p == NUM_PHASES - 1);

         // a small set of keys so that inserts collide and lookups hit
         foreach (key_pool[j]) key_pool[j] = 16'($urandom);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (roll < 38) r.kind = REQ_INSERT;
            else if (roll < 73) r.kind = REQ_LOOKUP;
            else if (roll < 95) r.kind = REQ_TICK;
            else r.kind = REQ_RSVD;
            if (pick < 15) r.key = 16'($urandom);
            else if (pick < 35) r.key = last_key;
            else r.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            r.ia = $urandom;
            r.oa = $urandom;
            if (r.kind == REQ_INSERT) last_key = r.key;
            send_req(r, 1'b0, RSP_NONE);
         end
      end

      settle();
      repeat (LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** nat_table_with_aging: PASSED **");
      end else begin
         $display("** nat_table_with_aging: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== nat_table_with_aging.f =====
hdl/ntwa_pkg.sv
hdl/ntwa_store.sv
hdl/ntwa_unit.sv
hdl/nat_table_with_aging.sv
dv/nat_table_with_aging_tb.sv
